@@ rtl/wsjd_pkg.sv @@
// Shared types and constants for the work-stealing job dispatcher.
// Holds the transaction structs, command and status codes, and sequencer states.
// No dependencies.
`default_nettype none

package wsjd_pkg;

  // Configuration register indexes.
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 4;
  localparam logic [CfgIdxW-1:0] REG_WORKER_COUNT = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_SHUTDOWN     = 1'd1;

  // Queue kinds, used as the top address bit of the job store.
  localparam logic KIND_GLOBAL = 1'b0;
  localparam logic KIND_LOCAL  = 1'b1;

  localparam int PendingW = 9;
  localparam logic [PendingW-1:0] PENDING_MAX = 9'd511;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_FETCH = 2'd1,
    CMD_DONE  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_SHUTDOWN = 2'd1,
    STAT_FULL     = 2'd2,
    STAT_NO_JOB   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TURN,
    S_PUSH,
    S_PROBE,
    S_READ
  } state_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [3:0]  worker_id;
    logic        affine;
    logic [15:0] job_tag;
  } req_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [15:0]         job_tag_out;
    logic                from_local;
    logic [2:0]          source_queue;
    logic [PendingW-1:0] jobs_pending;
  } rsp_t;

  // Pointer unit operation and the state of the selected queue.
  typedef struct packed {
    logic push;
    logic pop;
  } qop_t;

  typedef struct packed {
    logic empty;
    logic full;
  } qstat_t;

endpackage

`default_nettype wire

@@ rtl/work_stealing_job_dispatcher.sv @@
// Work-stealing job dispatcher: each worker owns a local and a global job FIFO.
// A transaction is taken when start is high and busy is low; its single result
// appears on rsp_o for exactly one cycle with done_o high, and the receiver
// cannot stall it, so it must capture the result in that cycle. Shutdown
// rejections, refusals at the pending ceiling, completions and unknown commands
// finish without leaving idle (done_o in the cycle after the accept). An affine
// add goes through the push state; a round-robin add first goes through the
// turn state, which subtracts the worker count while the turn has to be reduced
// after the worker count shrank. A fetch probes one queue per cycle through the
// shared pointer unit and then reads the job from the registered job store. It
// probes the worker's own queue of the preferred kind first; if that kind is
// global it then scans the global queues of the other workers, and it tries the
// other kind too. Busy stays high until the result is produced. There is no
// clearing pass after reset: the job store needs none, since only written
// slots are ever read.
// Depends on wsjd_pkg, wsjd_qctl and wsjd_ram.
`default_nettype none

module work_stealing_job_dispatcher import wsjd_pkg::*; #(
  parameter int MAX_WORKERS = 8,
  parameter int QUEUE_DEPTH = 16,
  parameter int TAG_BITS    = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // Command transaction.
  input  wire logic                start,
  output logic                     busy,
  input  wire req_t                req_i,
  // Result transaction.
  output logic                     done_o,
  output rsp_t                     rsp_o,
  // Configuration writes.
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  localparam int WW    = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam int PW    = $clog2(QUEUE_DEPTH);
  localparam int EffW  = 5;
  localparam int SW    = (TAG_BITS < 16) ? TAG_BITS : 16;
  localparam int AddrW = 1 + WW + PW;

  // Configuration registers.
  logic [3:0] wc_q;
  logic       shut_q;

  // Sequencer and job state.
  state_e            state_q, state_d;
  logic [WW-1:0]     wid_q, wid_d;       // requesting worker, clamped
  logic [WW-1:0]     qidx_q, qidx_d;     // push target queue
  logic [WW-1:0]     scan_q, scan_d;     // steal scan position
  logic [WW-1:0]     rem_q, rem_d;       // turn being reduced
  logic [WW-1:0]     turn_q, turn_d;
  logic [WW-1:0]     src_q, src_d;
  logic              kind_q, kind_d;
  logic              own_q, own_d;       // probing the worker's own queue
  logic              second_q, second_d; // trying the non-preferred kind
  logic [SW-1:0]     tag_q, tag_d;
  logic [MAX_WORKERS-1:0] pref_q, pref_d;
  logic [PendingW-1:0]    pending_q, pending_d;
  logic              done_d;
  logic              done_q;
  rsp_t              rsp_q, rsp_d;

  // Effective worker count and clamped request worker.
  logic [EffW-1:0] eff;
  logic [EffW-1:0] last_w;
  logic [WW-1:0]   req_wid;
  logic            acc;

  always_comb begin
    if (wc_q == '0) begin
      eff = EffW'(1);
    end else if (EffW'(wc_q) > EffW'(MAX_WORKERS)) begin
      eff = EffW'(MAX_WORKERS);
    end else begin
      eff = EffW'(wc_q);
    end
  end

  assign last_w  = eff - 1'b1;
  assign req_wid = (EffW'(req_i.worker_id) > last_w) ? WW'(last_w) : WW'(req_i.worker_id);
  assign acc     = start && !busy;
  assign busy    = (state_q != S_IDLE);

  // Pointer unit and job store.
  logic          q_kind;
  logic [WW-1:0] q_idx;
  qop_t          q_op;
  qstat_t        q_stat;
  logic [PW-1:0] q_pos;
  logic [SW-1:0] ram_rdata;

  wsjd_qctl #(
    .MAX_WORKERS (MAX_WORKERS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_qctl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .kind_i (q_kind),
    .idx_i  (q_idx),
    .op_i   (q_op),
    .stat_o (q_stat),
    .pos_o  (q_pos)
  );

  wsjd_ram #(
    .Width (SW),
    .Depth (2 ** AddrW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (q_op.push),
    .waddr_i ({q_kind, q_idx, q_pos}),
    .wdata_i (tag_q),
    .raddr_i ({q_kind, q_idx, q_pos}),
    .rdata_o (ram_rdata)
  );

  // Shared decisions of the sequencer.
  logic turn_big;   // the turn is still at or above the worker count
  logic probe_ok;   // the probed queue is a legal candidate
  logic probe_hit;
  logic try_done;   // no candidate left in the current kind

  assign turn_big  = (EffW'(rem_q) >= eff);
  assign probe_ok  = own_q || (scan_q != wid_q);
  assign probe_hit = probe_ok && !q_stat.empty;
  assign try_done  = own_q ? (kind_q == KIND_LOCAL) : (EffW'(scan_q) + 1'b1 >= eff);

  always_comb begin
    q_kind = kind_q;
    q_idx  = qidx_q;
    if (state_q == S_PROBE) begin
      q_idx = own_q ? wid_q : scan_q;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (acc) begin
          case (req_i.cmd)
            CMD_ADD: begin
              if (!shut_q && (pending_q < PENDING_MAX)) begin
                state_d = req_i.affine ? S_PUSH : S_TURN;
              end
            end
            CMD_FETCH: state_d = S_PROBE;
            default:   state_d = S_IDLE;
          endcase
        end
      end
      S_TURN: begin
        if (!turn_big) begin
          state_d = S_PUSH;
        end
      end
      S_PUSH: state_d = S_IDLE;
      S_PROBE: begin
        if (probe_hit) begin
          state_d = S_READ;
        end else if (try_done && second_q) begin
          state_d = S_IDLE;
        end
      end
      S_READ:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and result.
  always_comb begin
    wid_d     = wid_q;
    qidx_d    = qidx_q;
    scan_d    = scan_q;
    rem_d     = rem_q;
    turn_d    = turn_q;
    src_d     = src_q;
    kind_d    = kind_q;
    own_d     = own_q;
    second_d  = second_q;
    tag_d     = tag_q;
    pref_d    = pref_q;
    pending_d = pending_q;
    q_op      = '0;
    done_d    = 1'b0;
    rsp_d     = rsp_q;

    // Defaults for a finishing transaction; each path below overrides fields.
    rsp_d.status       = STAT_NO_JOB;
    rsp_d.job_tag_out  = '0;
    rsp_d.from_local   = 1'b0;
    rsp_d.source_queue = '0;

    case (state_q)
      S_IDLE: begin
        if (acc) begin
          wid_d = req_wid;
          tag_d = SW'(req_i.job_tag);
          case (req_i.cmd)
            CMD_ADD: begin
              if (shut_q) begin
                done_d       = 1'b1;
                rsp_d.status = STAT_SHUTDOWN;
              end else if (pending_q >= PENDING_MAX) begin
                done_d       = 1'b1;
                rsp_d.status = STAT_FULL;
              end else if (req_i.affine) begin
                kind_d = KIND_LOCAL;
                qidx_d = req_wid;
              end else begin
                kind_d = KIND_GLOBAL;
                rem_d  = turn_q;
              end
            end
            CMD_FETCH: begin
              kind_d          = pref_q[req_wid];
              pref_d[req_wid] = !pref_q[req_wid];
              own_d           = 1'b1;
              second_d        = 1'b0;
            end
            CMD_DONE: begin
              done_d = 1'b1;
              if (pending_q != '0) begin
                pending_d    = pending_q - 1'b1;
                rsp_d.status = STAT_OK;
              end
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end

      S_TURN: begin
        // A turn left over from a larger worker count is brought back in range
        // one subtraction per cycle; the stored turn itself stays untouched.
        if (turn_big) begin
          rem_d = WW'(EffW'(rem_q) - eff);
        end else begin
          qidx_d = rem_q;
        end
      end

      S_PUSH: begin
        done_d             = 1'b1;
        rsp_d.from_local   = kind_q;
        rsp_d.source_queue = 3'(qidx_q);
        if (q_stat.full) begin
          rsp_d.status = STAT_FULL;
        end else begin
          q_op.push    = 1'b1;
          pending_d    = pending_q + 1'b1;
          rsp_d.status = STAT_OK;
          if (kind_q == KIND_GLOBAL) begin
            turn_d = (EffW'(qidx_q) + 1'b1 == eff) ? '0 : qidx_q + 1'b1;
          end
        end
      end

      S_PROBE: begin
        if (probe_hit) begin
          q_op.pop = 1'b1;
          src_d    = q_idx;
        end else if (!try_done) begin
          if (own_q) begin
            own_d  = 1'b0;
            scan_d = '0;
          end else begin
            scan_d = scan_q + 1'b1;
          end
        end else if (!second_q) begin
          second_d = 1'b1;
          kind_d   = !kind_q;
          own_d    = 1'b1;
        end else begin
          done_d = 1'b1;
        end
      end

      S_READ: begin
        done_d             = 1'b1;
        rsp_d.status       = STAT_OK;
        rsp_d.job_tag_out  = 16'(ram_rdata);
        rsp_d.from_local   = kind_q;
        rsp_d.source_queue = 3'(src_q);
      end

      default: begin
      end
    endcase

    rsp_d.jobs_pending = pending_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      turn_q    <= '0;
      pref_q    <= '0;
      pending_q <= '0;
      done_q    <= 1'b0;
      wc_q      <= 4'd8;
      shut_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      turn_q    <= turn_d;
      pref_q    <= pref_d;
      pending_q <= pending_d;
      done_q    <= done_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_WORKER_COUNT: wc_q   <= cfg_data_i;
          REG_SHUTDOWN:     shut_q <= cfg_data_i[0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    wid_q    <= wid_d;
    qidx_q   <= qidx_d;
    scan_q   <= scan_d;
    rem_q    <= rem_d;
    src_q    <= src_d;
    kind_q   <= kind_d;
    own_q    <= own_d;
    second_q <= second_d;
    tag_q    <= tag_d;
    if (done_d) begin
      rsp_q <= rsp_d;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

`default_nettype wire

@@ rtl/wsjd_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module wsjd_ram #(
  parameter int Width = 16,
  parameter int Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ rtl/wsjd_qctl.sv @@
// Queue pointer unit: head and fill count of every local and global FIFO.
// Looks at one selected queue per cycle and gives its store slot.
// Depends on wsjd_pkg.
`default_nettype none

module wsjd_qctl import wsjd_pkg::*; #(
  parameter int MAX_WORKERS = 8,
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic                                         clk_i,
  input  wire logic                                         rst_ni,
  input  wire logic                                         kind_i,
  input  wire logic [(MAX_WORKERS > 1 ? $clog2(MAX_WORKERS) : 1)-1:0] idx_i,
  input  wire qop_t                                         op_i,
  output qstat_t                                            stat_o,
  output logic      [$clog2(QUEUE_DEPTH)-1:0]               pos_o
);

  localparam int WW   = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam int PW   = $clog2(QUEUE_DEPTH);
  localparam int CW   = $clog2(QUEUE_DEPTH + 1);
  localparam int SumW = CW + 1;

  logic [PW-1:0] head_q  [2][MAX_WORKERS];
  logic [CW-1:0] count_q [2][MAX_WORKERS];

  logic [PW-1:0]   head_sel;
  logic [CW-1:0]   count_sel;
  logic [SumW-1:0] tail_sum;
  logic [PW-1:0]   tail_pos;
  logic [PW-1:0]   head_next;

  assign head_sel  = head_q[kind_i][idx_i];
  assign count_sel = count_q[kind_i][idx_i];

  // The tail slot is head plus count, wrapped once at the depth.
  assign tail_sum = SumW'(head_sel) + SumW'(count_sel);
  assign tail_pos = (tail_sum >= SumW'(QUEUE_DEPTH)) ?
                    PW'(tail_sum - SumW'(QUEUE_DEPTH)) : PW'(tail_sum);
  assign head_next = (head_sel == PW'(QUEUE_DEPTH - 1)) ? '0 : head_sel + 1'b1;

  assign stat_o.empty = (count_sel == '0);
  assign stat_o.full  = (count_sel == CW'(QUEUE_DEPTH));
  assign pos_o        = op_i.push ? tail_pos : head_sel;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 2; k++) begin
        for (int w = 0; w < MAX_WORKERS; w++) begin
          head_q[k][w]  <= '0;
          count_q[k][w] <= '0;
        end
      end
    end else if (op_i.push) begin
      count_q[kind_i][idx_i] <= count_sel + 1'b1;
    end else if (op_i.pop) begin
      count_q[kind_i][idx_i] <= count_sel - 1'b1;
      head_q[kind_i][idx_i]  <= head_next;
    end
  end

endmodule

`default_nettype wire
